// ===== src/fingerprint_subset_screen_macros.svh =====
// Assertion macros shared by the screen's modules.
// Each macro samples on clk; the reset-gated form is quiet while rst_n is low.
`ifndef FINGERPRINT_SUBSET_SCREEN_MACROS_SVH
`define FINGERPRINT_SUBSET_SCREEN_MACROS_SVH

// Property checked outside reset.
`define FSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define FSS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/fss_pkg.sv =====
package fss_pkg;

  // Field widths of the items and the register.
  localparam int MAX_WORDS = 16;
  localparam int POS_W     = 4;
  localparam int WORD_W    = 64;
  localparam int ID_W      = 31;
  localparam int CNT_W     = 5;

  localparam logic [CNT_W-1:0] WORD_COUNT_RST = CNT_W'(16);

  // Item action codes.
  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TEST = 1'b1
  } action_t;

  // One input item.
  typedef struct packed {
    action_t            action;
    logic [POS_W-1:0]   word_position;
    logic [WORD_W-1:0]  word_bits;
    logic [ID_W-1:0]    target_id;
  } item_t;

  // Input register contents handed to the screen stage.
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // Write request into the query store.
  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  addr;
    logic [WORD_W-1:0] data;
  } qwrite_t;

  // Word count as used: zero acts as one, anything above the store acts as full.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] res;
    if (cnt == '0) begin
      res = CNT_W'(1);
    end else if (cnt > CNT_W'(MAX_WORDS)) begin
      res = CNT_W'(MAX_WORDS);
    end else begin
      res = cnt;
    end
    return res;
  endfunction

endpackage

// ===== src/fss_item_if.sv =====
interface fss_item_if;
  import fss_pkg::*;

  logic                     valid;
  logic                     ready;
  action_t                  action;
  logic [POS_W-1:0]         word_position;
  logic [WORD_W-1:0]        word_bits;
  logic [ID_W-1:0]          target_id;

  modport source (output valid, action, word_position, word_bits, target_id, input ready);
  modport sink   (input valid, action, word_position, word_bits, target_id, output ready);
endinterface

// ===== src/fss_hit_if.sv =====
interface fss_hit_if;
  import fss_pkg::*;

  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  hit_index;

  modport source (output valid, hit_index, input ready);
  modport sink   (input valid, hit_index, output ready);
endinterface

// ===== src/fss_in_stage.sv =====
module fss_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  fss_item_if.sink        in_ch,
  input  logic            take,
  output fss_pkg::stage_t st
);
  import fss_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  // The register frees up when its item moves on in the same cycle.
  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.action        <= in_ch.action;
      item_r.word_position <= in_ch.word_position;
      item_r.word_bits     <= in_ch.word_bits;
      item_r.target_id     <= in_ch.target_id;
    end
  end

  assign st.valid = valid_r;
  assign st.item  = item_r;
endmodule

// ===== src/fss_query_store.sv =====
module fss_query_store (
  input  logic                       clk,
  input  fss_pkg::qwrite_t           wr,
  input  logic [fss_pkg::POS_W-1:0]  raddr,
  output logic [fss_pkg::WORD_W-1:0] rdata
);
  import fss_pkg::*;

  // Query words; entries hold nothing meaningful until loaded.
  logic [WORD_W-1:0] words_r [MAX_WORDS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      words_r[wr.addr] <= wr.data;
    end
  end

  assign rdata = words_r[raddr];
endmodule

// ===== src/fss_match.sv =====
`include "fingerprint_subset_screen_macros.svh"

module fss_match (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fss_pkg::stage_t            st,
  input  logic [fss_pkg::WORD_W-1:0] qword,
  input  logic                       cfg_we,
  input  logic [fss_pkg::CNT_W-1:0]  cfg_wdata,
  output logic                       take,
  output fss_pkg::qwrite_t           qwr,
  fss_hit_if.source                  out_ch
);
  import fss_pkg::*;

  logic [CNT_W-1:0] word_count_r;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pos_ext;
  logic             is_test;
  logic             in_range;
  logic             last_word;
  logic             word_ok;
  logic             flag_run;
  logic             flag_r;
  logic             flag_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [ID_W-1:0]  hit_r;
  logic [ID_W-1:0]  hit_nxt;

  // Word count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_count_r <= WORD_COUNT_RST;
    end else if (cfg_we) begin
      word_count_r <= cfg_wdata;
    end
  end

  // The item moves on whenever the result register is empty or being drained.
  assign take = st.valid && (!out_valid_r || out_ch.ready);

  // Decode of the current item against the word count.
  assign count     = eff_count(word_count_r);
  assign pos_ext   = {1'b0, st.item.word_position};
  assign is_test   = (st.item.action == ACT_TEST);
  assign in_range  = (pos_ext < count);
  assign last_word = (pos_ext == (count - CNT_W'(1)));

  // Containment test: every query bit must be set in the target word.
  assign word_ok  = ((qword & st.item.word_bits) == qword);
  assign flag_run = (st.item.word_position == '0) ? word_ok : (flag_r && word_ok);

  // Query loads write the store as the item moves on.
  assign qwr.we   = take && !is_test && (pos_ext < CNT_W'(MAX_WORDS));
  assign qwr.addr = st.item.word_position;
  assign qwr.data = st.item.word_bits;

  // Running flag and result register.
  always_comb begin
    flag_nxt      = flag_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    hit_nxt       = hit_r;
    if (take && is_test && in_range) begin
      flag_nxt = last_word ? 1'b1 : flag_run;
      if (last_word && flag_run) begin
        out_valid_nxt = 1'b1;
        hit_nxt       = st.item.target_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      flag_r      <= flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit_index = hit_r;

  // The flag is back to one once a target's last word has gone by.
  `FSS_ASSERT(a_flag_rearm, (take && is_test && in_range && last_word) |=> flag_r, "flag not rearmed after last word")
  // Query loads leave the running flag alone.
  `FSS_ASSERT(a_load_keeps_flag, (take && !is_test) |=> $stable(flag_r), "load changed the running flag")
  // Only a target's last word can leave a result behind it.
  `FSS_ASSERT(a_hit_source, (take && !(is_test && in_range && last_word)) |=> !out_valid_r, "result without a last target word")
endmodule

// ===== src/fingerprint_subset_screen.sv =====
// Fingerprint containment screen.
// in_ch carries items: a load item (action 0) writes word_bits into the query
// word at word_position; a test item (action 1) checks one target word against
// the query word at the same position. A target whose words all contain every
// query bit yields one item on out_ch carrying the target_id of its last word.
// Which position is last follows cfg_wdata, written with cfg_we while idle
// (zero acts as one word, above sixteen as sixteen); test words beyond it are
// dropped. Load the query before streaming targets.
// Path: a target's last word is accepted into the input register, where the
// AND-compare runs, and the result register loads as the word moves on out
// of it; out_ch shows the result from the result register. Throughput is one
// item per cycle while out_ch is not stalled, set by the single compare per
// word; an empty input register still accepts one item while a result waits.
// Reset empties the pipeline, sets the running flag and sets the word count to
// 16; query words are undefined until loaded. If out_ch stalls, the result
// holds, the item behind it waits in the input register and in_ch.ready drops.
module fingerprint_subset_screen (
  input  logic                      clk,
  input  logic                      rst_n,
  fss_item_if.sink                  in_ch,
  fss_hit_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [fss_pkg::CNT_W-1:0] cfg_wdata
);
  import fss_pkg::*;

  stage_t            st;
  logic              take;
  qwrite_t           qwr;
  logic [WORD_W-1:0] qword;

  fss_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .st    (st)
  );

  fss_query_store u_query_store (
    .clk   (clk),
    .wr    (qwr),
    .raddr (st.item.word_position),
    .rdata (qword)
  );

  fss_match u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .st        (st),
    .qword     (qword),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .take      (take),
    .qwr       (qwr),
    .out_ch    (out_ch)
  );
endmodule
